// File: rtl/core/bhist_pkg.sv
package bhist_pkg;

  // defaults for the top-level parameters
  localparam int SYMBOL_BITS_DEF = 8;
  localparam int COUNT_WIDTH_DEF = 32;

  // fixed field widths of the stream items
  localparam int REQ_W    = 2;
  localparam int SYM_W    = 8;
  localparam int SCALE_W  = 8;
  localparam int LEN_W    = 8;
  localparam int OUT_CW   = 32;
  localparam int OUT_DATA_W = LEN_W + 2 * OUT_CW;

  localparam logic [SCALE_W-1:0] BAR_SCALE_RESET = 8'd76;

  // request codes on the input stream
  localparam logic [REQ_W-1:0] REQ_COUNT = 2'd0;
  localparam logic [REQ_W-1:0] REQ_QUERY = 2'd1;
  localparam logic [REQ_W-1:0] REQ_CLEAR = 2'd2;

  // command queue between front and back
  localparam int QUEUE_DEPTH = 4;
  localparam int QUEUE_AW    = 2;

  typedef enum logic [1:0] {
    OP_COUNT,
    OP_QUERY,
    OP_CLEAR
  } op_t;

  typedef struct packed {
    op_t              op;
    logic [SYM_W-1:0] symbol;
  } q_entry_t;

  typedef struct packed {
    logic sweep_busy;
    logic init_done;
  } back_status_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_CNT_WR,
    ST_Q_RD,
    ST_DIV,
    ST_OUT
  } back_state_t;

endpackage

// File: rtl/core/byte_histogram_scaled_bars_top.sv
// byte histogram with scaled bars: each input item either counts a byte into one of
// 2^SYMBOL_BITS saturating bins, queries a bin, or clears the whole histogram. a query
// returns one item with the raw count, the running maximum, a bar length of
// count * bar_scale / maximum (truncated, at least 1 for a nonzero count) and a no-data
// flag. a front stage classifies items into a four-entry command queue, so the input
// keeps flowing while the back end works, until the queue is full. the back end owns
// the bin memory (one write port, one registered read port) and does one command at a
// time: a count is a read-modify-write, a query reads the bin, runs eight quotient-bit
// steps of the restoring divider and loads the output register (the divider is skipped
// when the bin or the maximum is zero, and the load waits for the output register to
// be free), and a clear walks the memory one bin per cycle. after reset the same clear
// walk runs before the first item is accepted; configuration writes are taken during it
module byte_histogram_scaled_bars_top
  import bhist_pkg::*;
#(
  parameter int SYMBOL_BITS = SYMBOL_BITS_DEF,
  parameter int COUNT_WIDTH = COUNT_WIDTH_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  // bar scale register
  input  logic                  cfg_wr_en,
  input  logic [SCALE_W-1:0]    cfg_wr_data,
  // request items
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [SYM_W-1:0]      in_tdata,    // symbol[7:0]
  input  logic [REQ_W-1:0]      in_tuser,    // req_type[1:0]
  // query result items
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [OUT_DATA_W-1:0] out_tdata,   // scaled_length[7:0], raw_count[39:8],
                                             // max_count[71:40]
  output logic                  out_tuser    // no_data[0]
);

  back_status_t back_status;
  q_entry_t     push_entry;
  q_entry_t     head_entry;
  logic         q_push, q_pop, q_full, q_empty;

  // front: handshake and request decode
  bhist_front u_front (
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .in_tuser    (in_tuser),
    .back_status (back_status),
    .q_full      (q_full),
    .q_push      (q_push),
    .q_entry     (push_entry)
  );

  // command queue decouples the input stream from the back end
  bhist_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (q_push),
    .push_entry (push_entry),
    .pop        (q_pop),
    .head_entry (head_entry),
    .full       (q_full),
    .empty      (q_empty)
  );

  // back: bin memory, running max, divider and result register
  bhist_back #(
    .SYMBOL_BITS (SYMBOL_BITS),
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .q_empty     (q_empty),
    .q_head      (head_entry),
    .q_pop       (q_pop),
    .back_status (back_status),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .out_tuser   (out_tuser)
  );

endmodule

// File: rtl/core/bhist_queue.sv
module bhist_queue
  import bhist_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     push,
  input  q_entry_t push_entry,
  input  logic     pop,
  output q_entry_t head_entry,
  output logic     full,
  output logic     empty
);

  q_entry_t              slots_r [QUEUE_DEPTH];
  logic [QUEUE_AW-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [QUEUE_AW-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [QUEUE_AW:0]     fill_r, fill_nxt;
  logic                  do_push, do_pop;

  assign full       = (fill_r == QUEUE_AW'(0) + (QUEUE_AW+1)'(QUEUE_DEPTH));
  assign empty      = (fill_r == '0);
  assign head_entry = slots_r[rd_ptr_r];
  assign do_push    = push && !full;
  assign do_pop     = pop && !empty;

  always_comb begin
    wr_ptr_nxt = do_push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = do_pop ? rd_ptr_r + 1'b1 : rd_ptr_r;
    fill_nxt   = fill_r;
    if (do_push && !do_pop) begin
      fill_nxt = fill_r + 1'b1;
    end else if (do_pop && !do_push) begin
      fill_nxt = fill_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      fill_r   <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      fill_r   <= fill_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots_r[wr_ptr_r] <= push_entry;
    end
  end

endmodule

// File: rtl/core/bhist_front.sv
module bhist_front
  import bhist_pkg::*;
(
  input  logic             in_tvalid,
  output logic             in_tready,
  input  logic [SYM_W-1:0] in_tdata,
  input  logic [REQ_W-1:0] in_tuser,
  input  back_status_t     back_status,
  input  logic             q_full,
  output logic             q_push,
  output q_entry_t         q_entry
);

  logic accept;
  logic known;

  // hold off while the start-up clear pass runs or the queue is full
  assign in_tready = !q_full && !back_status.sweep_busy && back_status.init_done;
  assign accept    = in_tvalid && in_tready;

  always_comb begin
    q_entry.symbol = in_tdata;
    q_entry.op     = OP_COUNT;
    known          = 1'b1;
    case (in_tuser)
      REQ_COUNT: q_entry.op = OP_COUNT;
      REQ_QUERY: q_entry.op = OP_QUERY;
      REQ_CLEAR: q_entry.op = OP_CLEAR;
      default:   known      = 1'b0;  // unused code: taken and dropped
    endcase
  end

  assign q_push = accept && known;

endmodule

// File: rtl/core/bhist_back.sv
module bhist_back
  import bhist_pkg::*;
#(
  parameter int SYMBOL_BITS = SYMBOL_BITS_DEF,
  parameter int COUNT_WIDTH = COUNT_WIDTH_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_wr_en,
  input  logic [SCALE_W-1:0]    cfg_wr_data,
  input  logic                  q_empty,
  input  q_entry_t              q_head,
  output logic                  q_pop,
  output back_status_t          back_status,
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [OUT_DATA_W-1:0] out_tdata,
  output logic                  out_tuser
);

  localparam int NUM_BINS = 1 << SYMBOL_BITS;
  localparam int NUM_W    = COUNT_WIDTH + SCALE_W;
  localparam int STEP_W   = $clog2(LEN_W);

  logic [COUNT_WIDTH-1:0] bins_mem [NUM_BINS];
  logic [COUNT_WIDTH-1:0] rd_data_r;
  logic [SYMBOL_BITS-1:0] rd_addr;
  logic                   wr_en;
  logic [SYMBOL_BITS-1:0] wr_addr;
  logic [COUNT_WIDTH-1:0] wr_data;

  back_state_t            state_r, state_nxt;
  logic [SYMBOL_BITS-1:0] clr_idx_r, clr_idx_nxt;
  logic [SYMBOL_BITS-1:0] bin_r, bin_nxt;
  logic [COUNT_WIDTH-1:0] max_r, max_nxt;
  logic [COUNT_WIDTH-1:0] cnt_r, cnt_nxt;
  logic [NUM_W-1:0]       num_r, num_nxt;
  logic [LEN_W-1:0]       quot_r, quot_nxt;
  logic [STEP_W-1:0]      step_r, step_nxt;
  logic [SCALE_W-1:0]     scale_r;
  logic                   init_done_r, init_done_nxt;

  logic                   out_valid_r, out_valid_nxt;
  logic [OUT_DATA_W-1:0]  out_data_r, out_data_nxt;
  logic                   out_nodata_r, out_nodata_nxt;

  logic [SYMBOL_BITS-1:0] head_bin;
  logic [COUNT_WIDTH-1:0] inc_cnt;
  logic [NUM_W-1:0]       div_cmp;
  logic                   out_free;
  logic [LEN_W-1:0]       bar_len;
  logic [COUNT_WIDTH+OUT_CW-1:0] cnt_ext, max_ext;
  logic [SYMBOL_BITS+SYM_W-1:0]  sym_ext;

  assign sym_ext  = {{SYMBOL_BITS{1'b0}}, q_head.symbol};
  assign head_bin = sym_ext[SYMBOL_BITS-1:0];
  assign inc_cnt  = (rd_data_r == '1) ? rd_data_r : rd_data_r + 1'b1;
  assign div_cmp  = {{SCALE_W{1'b0}}, max_r} << step_r;
  assign out_free = !out_valid_r || out_tready;
  assign cnt_ext  = {{OUT_CW{1'b0}}, cnt_r};
  assign max_ext  = {{OUT_CW{1'b0}}, max_r};

  always_comb begin
    if (cnt_r == '0 || max_r == '0) begin
      bar_len = '0;
    end else if (quot_r == '0) begin
      bar_len = LEN_W'(1);
    end else begin
      bar_len = quot_r;
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_CLEAR: begin
        if (clr_idx_r == '1) state_nxt = ST_IDLE;
      end
      ST_IDLE: begin
        if (!q_empty) begin
          case (q_head.op)
            OP_COUNT: state_nxt = ST_CNT_WR;
            OP_QUERY: state_nxt = ST_Q_RD;
            OP_CLEAR: state_nxt = ST_CLEAR;
            default:  state_nxt = ST_IDLE;
          endcase
        end
      end
      ST_CNT_WR: state_nxt = ST_IDLE;
      ST_Q_RD: begin
        if (rd_data_r == '0 || max_r == '0) state_nxt = ST_OUT;
        else                                 state_nxt = ST_DIV;
      end
      ST_DIV: begin
        if (step_r == '0) state_nxt = ST_OUT;
      end
      ST_OUT: begin
        if (out_free) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // datapath and outputs
  always_comb begin
    q_pop          = 1'b0;
    rd_addr        = head_bin;
    wr_en          = 1'b0;
    wr_addr        = bin_r;
    wr_data        = inc_cnt;
    clr_idx_nxt    = clr_idx_r;
    bin_nxt        = bin_r;
    max_nxt        = max_r;
    cnt_nxt        = cnt_r;
    num_nxt        = num_r;
    quot_nxt       = quot_r;
    step_nxt       = step_r;
    init_done_nxt  = init_done_r;
    out_valid_nxt  = out_valid_r && !out_tready;
    out_data_nxt   = out_data_r;
    out_nodata_nxt = out_nodata_r;
    case (state_r)
      ST_CLEAR: begin
        wr_en       = 1'b1;
        wr_addr     = clr_idx_r;
        wr_data     = '0;
        max_nxt     = '0;
        clr_idx_nxt = clr_idx_r + 1'b1;
        if (clr_idx_r == '1) init_done_nxt = 1'b1;
      end
      ST_IDLE: begin
        if (!q_empty) begin
          q_pop   = 1'b1;
          bin_nxt = head_bin;
          if (q_head.op == OP_CLEAR) clr_idx_nxt = '0;
        end
      end
      ST_CNT_WR: begin
        wr_en = 1'b1;
        if (inc_cnt > max_r) max_nxt = inc_cnt;
      end
      ST_Q_RD: begin
        cnt_nxt  = rd_data_r;
        num_nxt  = NUM_W'(rd_data_r) * NUM_W'(scale_r);
        quot_nxt = '0;
        step_nxt = STEP_W'(LEN_W - 1);
      end
      ST_DIV: begin
        // one restoring quotient bit per cycle, msb first
        if (num_r >= div_cmp) begin
          num_nxt  = num_r - div_cmp;
          quot_nxt = quot_r | (LEN_W'(1) << step_r);
        end
        step_nxt = step_r - 1'b1;
      end
      ST_OUT: begin
        if (out_free) begin
          out_valid_nxt  = 1'b1;
          out_data_nxt   = {max_ext[OUT_CW-1:0], cnt_ext[OUT_CW-1:0], bar_len};
          out_nodata_nxt = (max_r == '0);
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      clr_idx_r   <= '0;
      max_r       <= '0;
      init_done_r <= 1'b0;
      out_valid_r <= 1'b0;
      scale_r     <= BAR_SCALE_RESET;
    end else begin
      state_r     <= state_nxt;
      clr_idx_r   <= clr_idx_nxt;
      max_r       <= max_nxt;
      init_done_r <= init_done_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_wr_en) scale_r <= cfg_wr_data;
    end
  end

  always_ff @(posedge clk) begin
    bin_r        <= bin_nxt;
    cnt_r        <= cnt_nxt;
    num_r        <= num_nxt;
    quot_r       <= quot_nxt;
    step_r       <= step_nxt;
    out_data_r   <= out_data_nxt;
    out_nodata_r <= out_nodata_nxt;
  end

  always_ff @(posedge clk) begin
    if (wr_en) bins_mem[wr_addr] <= wr_data;
    rd_data_r <= bins_mem[rd_addr];
  end

  assign back_status.sweep_busy = (state_r == ST_CLEAR) && !init_done_r;
  assign back_status.init_done  = init_done_r;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_nodata_r;

endmodule
